### design/gsf_pkg.sv
package gsf_pkg;

    // Default configuration of the filter
    localparam int unsigned HALF_WIDTH_DEF  = 50;
    localparam int unsigned SAMPLE_BITS_DEF = 16;
    localparam int unsigned COEF_BITS_DEF   = 18;

    // Port field widths, fixed by the stream format
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SMOOTH_W = 16;

    localparam logic [63:0] Q32_ONE  = 64'h1_0000_0000;
    localparam logic [63:0] Q32_HALF = 64'h8000_0000;

    // Restoring shift-subtract division, used only to build constants
    function automatic logic [63:0] gsf_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q32 product, rounded half up
    function automatic logic [63:0] gsf_mulq32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] prod;
        prod = a * b + Q32_HALF;
        return prod >> 32;
    endfunction

    // Gaussian tap weight for distance d, unsigned Q0.coef_bits, unit DC gain
    function automatic logic [63:0] gsf_coef(input int unsigned d,
                                             input int unsigned hw,
                                             input int unsigned coef_bits);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] q;
        logic [63:0] w;
        logic [63:0] wd;
        logic [63:0] total;
        logic [63:0] k;
        term = Q32_ONE;
        pos  = Q32_ONE;
        neg  = '0;
        k    = 64'd1;
        // exp(-1/(2*hw)) as a truncated Taylor series
        while (term != 64'd0 && k < 64'd64) begin
            term = gsf_div(term, 64'(2 * hw) * k);
            if (k[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
            k = k + 64'd1;
        end
        r     = pos - neg;
        r2    = gsf_mulq32(r, r);
        q     = r;
        w     = Q32_ONE;
        total = w;
        wd    = (d == 0) ? w : 64'd0;
        // w[i] = w[i-1] * r^(2i-1)
        for (int unsigned i = 1; i <= hw; i++) begin
            w     = gsf_mulq32(w, q);
            q     = gsf_mulq32(q, r2);
            total = total + (w << 1);
            if (i == d) begin
                wd = w;
            end
        end
        return gsf_div((wd << coef_bits) + (total >> 1), total);
    endfunction

endpackage

### design/gsf_cell.sv
module gsf_cell #(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned COEF_BITS   = 18,
    parameter int unsigned ACC_W       = 41,
    parameter logic [COEF_BITS-1:0] COEF = '0
) (
    input  logic                   aclk,
    input  logic                   step,
    input  logic                   clr,
    input  logic [SAMPLE_BITS-1:0] x,
    input  logic [ACC_W-1:0]       psum_in,
    output logic [ACC_W-1:0]       psum_out
);

    logic [SAMPLE_BITS+COEF_BITS-1:0] prod;
    logic [ACC_W-1:0]                 psum_reg;
    logic [ACC_W-1:0]                 psum_next;

    // One tap: weight the broadcast sample and add the upstream partial sum.
    // At row start the upstream history is dropped.
    assign prod      = x * COEF;
    assign psum_next = ACC_W'(prod) + (clr ? '0 : psum_in);

    always_ff @(posedge aclk) begin
        if (step) begin
            psum_reg <= psum_next;
        end
    end

    assign psum_out = psum_reg;

endmodule

### design/gaussian_smoothing_fir.sv
// Gaussian row smoother, symmetric FIR of 2*HALF_WIDTH+1 taps.
// Input stream: s_tdata carries one unsigned Q8.8 sample, s_tlast marks the
// last sample of a row. Output stream: m_tdata carries the smoothed sample,
// m_tlast marks the final result of the row.
// The taps form a transposed chain of cells; each accepted sample is
// broadcast to all cells and the partial sums move one cell per cycle while the chain is not stalled.
// Throughput: one sample per cycle inside a row unless the output stalls.
// After the s_tlast transfer the chain shifts in HALF_WIDTH zeros to flush
// the pending outputs, so a row of N samples takes N + HALF_WIDTH steps.
// The result centered on a sample is complete at the step that takes the
// sample HALF_WIDTH later; rounding is combinational and the output
// register presents it once the register is free.
// Samples outside the row read as zero; each row starts from a clean chain.
// Reset (aresetn low, synchronous) drops any row in progress and empties
// the output register. When m_tready is low a valid output register holds, the
// chain stalls once its result cannot move on, and s_tready falls.
module gaussian_smoothing_fir
    #(
    parameter int unsigned HALF_WIDTH  = gsf_pkg::HALF_WIDTH_DEF,
    parameter int unsigned SAMPLE_BITS = gsf_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned COEF_BITS   = gsf_pkg::COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gsf_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                          s_tlast,   // row_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gsf_pkg::SMOOTH_W-1:0]  m_tdata,   // [15:0] smoothed
    output logic                          m_tlast    // row_done
);
    import gsf_pkg::*;

    localparam int unsigned TAPS   = 2 * HALF_WIDTH + 1;
    localparam int unsigned ACC_W  = SAMPLE_BITS + COEF_BITS + $clog2(TAPS);
    localparam int unsigned Y_W    = ACC_W + 1 - COEF_BITS;
    localparam int unsigned CNT_W  = $clog2(HALF_WIDTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HALF_WIDTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Control
    logic             flush_reg;
    logic             flush_next;
    logic [CNT_W-1:0] flush_cnt_reg;
    logic [CNT_W-1:0] flush_cnt_next;
    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic             row_start_reg;
    logic             row_start_next;
    logic             emit_reg;
    logic             emit_next;
    logic             done_reg;
    logic             done_next;
    logic             out_free;
    logic             adv;
    logic             in_xfer;
    logic             step;
    logic             last_flush;

    // Datapath
    logic [SAMPLE_BITS+SAMPLE_W-1:0] s_ext;
    logic [SAMPLE_BITS-1:0]          x_step;
    logic [ACC_W-1:0]                psum [0:TAPS];
    logic [ACC_W:0]                  rounded;
    logic [Y_W-1:0]                  y_full;
    logic [SAMPLE_BITS-1:0]          y_sat;
    logic [SAMPLE_BITS+SMOOTH_W-1:0] y_ext;
    logic                            m_tvalid_reg;
    logic [SMOOTH_W-1:0]             m_tdata_reg;
    logic                            m_tlast_reg;

    // Handshake and chain advance
    assign out_free   = !m_tvalid_reg || m_tready;
    assign adv        = !emit_reg || out_free;
    assign s_tready   = adv && !flush_reg;
    assign in_xfer    = s_tvalid && s_tready;
    assign step       = in_xfer || (flush_reg && adv);
    assign last_flush = flush_reg && (flush_cnt_reg == CNT_ONE);

    // Sample width adaption; zeros go in while flushing
    assign s_ext  = {{SAMPLE_BITS{1'b0}}, s_tdata};
    assign x_step = flush_reg ? '0 : s_ext[SAMPLE_BITS-1:0];

    // Row bookkeeping
    always_comb begin
        flush_next     = flush_reg;
        flush_cnt_next = flush_cnt_reg;
        pend_next      = pend_reg;
        row_start_next = row_start_reg;
        emit_next      = emit_reg;
        done_next      = done_reg;
        if (adv) begin
            emit_next = step && (pend_reg == CNT_FULL);
            done_next = step && last_flush;
        end
        if (step) begin
            row_start_next = last_flush;
            if (last_flush) begin
                pend_next = '0;
            end else if (pend_reg != CNT_FULL) begin
                pend_next = pend_reg + CNT_ONE;
            end
            if (flush_reg) begin
                flush_cnt_next = flush_cnt_reg - CNT_ONE;
                flush_next     = !last_flush;
            end else if (s_tlast) begin
                flush_cnt_next = CNT_FULL;
                flush_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_reg     <= 1'b0;
            flush_cnt_reg <= '0;
            pend_reg      <= '0;
            row_start_reg <= 1'b1;
            emit_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            flush_reg     <= flush_next;
            flush_cnt_reg <= flush_cnt_next;
            pend_reg      <= pend_next;
            row_start_reg <= row_start_next;
            emit_reg      <= emit_next;
            done_reg      <= done_next;
        end
    end

    // Tap chain: cell k weights the sample that is k steps old
    assign psum[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        localparam int unsigned DIST = (k < HALF_WIDTH) ? (HALF_WIDTH - k) : (k - HALF_WIDTH);
        localparam logic [63:0] COEF_FULL = gsf_coef(DIST, HALF_WIDTH, COEF_BITS);

        gsf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS),
            .ACC_W       (ACC_W),
            .COEF        (COEF_FULL[COEF_BITS-1:0])
        ) u_cell (
            .aclk     (aclk),
            .step     (step),
            .clr      (row_start_reg),
            .x        (x_step),
            .psum_in  (psum[k+1]),
            .psum_out (psum[k])
        );
    end

    // Round half up, saturate, fit to the output field
    assign rounded = {1'b0, psum[0]} + ((ACC_W+1)'(1) << (COEF_BITS - 1));
    assign y_full  = rounded[ACC_W:COEF_BITS];
    assign y_sat   = (|(y_full >> SAMPLE_BITS)) ? '1 : y_full[SAMPLE_BITS-1:0];
    assign y_ext   = {{SMOOTH_W{1'b0}}, y_sat};

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && emit_reg) begin
            m_tdata_reg <= y_ext[SMOOTH_W-1:0];
            m_tlast_reg <= done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_no_input_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> !s_tready)
        else $error("input taken during row flush");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_reg && m_tvalid_reg && !m_tready) |-> !step)
        else $error("chain advanced while its result was blocked");

    a_last_flush_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && last_flush) |-> (pend_reg == CNT_FULL))
        else $error("final flush step without a result");

    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= CNT_FULL)
        else $error("pending count out of range");

    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && last_flush) |=> (row_start_reg && !flush_reg && pend_reg == '0))
        else $error("row state not cleared after flush");

endmodule
